FILE: rtl/rrds_pkg.sv
// ----------------------------------------------------------------------------
// rrds_pkg
// Shared constants, command codes, cell control word and sequencer states
// for the round-robin delay scheduler.
// ----------------------------------------------------------------------------
package rrds_pkg;

  localparam int NumTasksDefault = 8;
  localparam int TickW           = 32;
  localparam int TaskOutW        = 3;
  localparam int MaskOutW        = 8;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_DELAY = 1'b1;

  typedef struct packed {
    logic             load;
    logic             shift;
    logic             wake_chk;
    logic             block;
    logic [TickW-1:0] counter;
    logic [TickW-1:0] wake_new;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WAKE = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_OUT  = 4'b1000
  } seq_state_t;

endpackage

FILE: rtl/rrds_cell.sv
// ----------------------------------------------------------------------------
// rrds_cell
// One task slot: ready bit, wake time and a scan token that moves on to the
// next slot of the ring every scan cycle.
// ----------------------------------------------------------------------------
module rrds_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  rrds_pkg::cell_ctl_t ctl,
  input  logic               start_sel,
  input  logic               block_sel,
  input  logic               token_in,
  output logic               token,
  output logic               ready,
  output logic               hit
);
  import rrds_pkg::*;

  logic [TickW-1:0] wake;

  always_ff @(posedge clk) begin
    if (rst) begin
      token <= 1'b0;
    end else if (ctl.load) begin
      token <= start_sel;
    end else if (ctl.shift) begin
      token <= token_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= 1'b1;
    end else if (ctl.block && block_sel) begin
      ready <= 1'b0;
    end else if (ctl.wake_chk && !ready && (ctl.counter >= wake)) begin
      ready <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.block && block_sel) begin
      wake <= ctl.wake_new;
    end
  end

  assign hit = token && ready && (IDX != 0);

endmodule

FILE: rtl/round_robin_delay_scheduler_unit.sv
// ----------------------------------------------------------------------------
// round_robin_delay_scheduler_unit
// Round-robin task scheduler with tick-based delays, built as a ring of
// task cells that a scan token walks through.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word: command and
//   delay_ticks. Command tick advances the tick counter, wakes blocked tasks
//   whose wake time has come and picks the next task. Command delay blocks
//   the running task until counter plus delay_ticks and picks the next task;
//   with the idle task running it changes nothing.
//   Output channel (out_valid / out_stall) returns one word per input word:
//   current_task, tick_value and ready_mask after the update.
//   The token walk through the ring, one slot per cycle, sets how long a
//   word takes to finish; one word is in work at a time.
//   The next input word is taken while a result still waits in the output
//   register; a stalled result holds, and the finished next result waits
//   in the sequencer until the register is free.
//   Reset: counter 0, task 1 running, every task ready, output empty.
// ----------------------------------------------------------------------------
module round_robin_delay_scheduler_unit #(
  parameter int NUM_TASKS = rrds_pkg::NumTasksDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [rrds_pkg::TickW-1:0]    delay_ticks,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rrds_pkg::TaskOutW-1:0] current_task,
  output logic [rrds_pkg::TickW-1:0]    tick_value,
  output logic [rrds_pkg::MaskOutW-1:0] ready_mask
);
  import rrds_pkg::*;

  localparam int TW = $clog2(NUM_TASKS);

  seq_state_t       state, state_next;
  logic [TickW-1:0] tick_counter;
  logic [TW-1:0]    running;
  logic [TW-1:0]    step;
  logic [TW-1:0]    start_idx;
  logic [TW-1:0]    hit_idx;
  logic             any_hit;
  logic             accept;
  logic             out_free;
  cell_ctl_t        ctl;

  logic [NUM_TASKS-1:0] start_sel;
  logic [NUM_TASKS-1:0] block_sel;
  logic [NUM_TASKS-1:0] token;
  logic [NUM_TASKS-1:0] ready;
  logic [NUM_TASKS-1:0] hit;
  logic [MaskOutW-1:0]  mask;
  logic [31:0]          run_ext;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign start_idx = (running == TW'(NUM_TASKS - 1)) ? '0 : running + 1'b1;

  always_comb begin
    ctl          = '0;
    ctl.load     = accept;
    ctl.block    = accept && (command == CMD_DELAY) && (running != '0);
    ctl.wake_chk = (state == ST_WAKE);
    ctl.shift    = (state == ST_SCAN);
    ctl.counter  = tick_counter;
    ctl.wake_new = tick_counter + delay_ticks;
  end

  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    localparam int PREV = (i + NUM_TASKS - 1) % NUM_TASKS;

    assign start_sel[i] = (start_idx == TW'(i));
    assign block_sel[i] = (running == TW'(i)) && (i != 0);

    rrds_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .start_sel (start_sel[i]),
      .block_sel (block_sel[i]),
      .token_in  (token[PREV]),
      .token     (token[i]),
      .ready     (ready[i]),
      .hit       (hit[i])
    );
  end

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (hit[i]) begin
        hit_idx = hit_idx | TW'(i);
      end
    end
  end

  assign any_hit = |hit;

  for (genvar i = 0; i < MaskOutW; i++) begin : g_mask
    if (i < NUM_TASKS) begin : g_on
      assign mask[i] = ready[i];
    end else begin : g_off
      assign mask[i] = 1'b0;
    end
  end

  assign run_ext = 32'(running);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (command == CMD_TICK) begin
            state_next = ST_WAKE;
          end else if (running != '0) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_WAKE: state_next = ST_SCAN;
      ST_SCAN: begin
        if (any_hit || (step == TW'(NUM_TASKS - 1))) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tick_counter <= '0;
      running      <= TW'(1);
      step         <= '0;
    end else begin
      state <= state_next;
      if (accept && (command == CMD_TICK)) begin
        tick_counter <= tick_counter + 1'b1;
      end
      if (accept) begin
        step <= '0;
      end else if (state == ST_SCAN) begin
        step <= step + 1'b1;
        if (any_hit) begin
          running <= hit_idx;
        end else if (step == TW'(NUM_TASKS - 1)) begin
          running <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && out_free) begin
      current_task <= run_ext[TaskOutW-1:0];
      tick_value   <= tick_counter;
      ready_mask   <= mask;
    end
  end

endmodule

FILE: rtl/rrds_checker.sv
// ----------------------------------------------------------------------------
// rrds_checker
// Port-level checks for the round-robin delay scheduler, bound to the top.
// ----------------------------------------------------------------------------
module rrds_checker #(
  parameter int NUM_TASKS = rrds_pkg::NumTasksDefault
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rrds_pkg::TaskOutW-1:0] current_task,
  input logic [rrds_pkg::MaskOutW-1:0] ready_mask
);
  import rrds_pkg::*;

  // a held result word stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // the idle slot is always ready
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ready_mask[0])
    else $error("idle task shown not ready");

  // a chosen user task is ready
  a_task_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && (current_task != '0) && (NUM_TASKS <= MaskOutW)
      |-> ready_mask[current_task])
    else $error("chosen task not ready");

  // one word in work at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

endmodule

bind round_robin_delay_scheduler_unit rrds_checker #(
  .NUM_TASKS (NUM_TASKS)
) u_rrds_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .current_task (current_task),
  .ready_mask   (ready_mask)
);

FILE: tb/tb_round_robin_delay_scheduler_unit.sv
// ----------------------------------------------------------------------------
// tb_round_robin_delay_scheduler_unit
// Self-checking bench for the round-robin delay scheduler. A directed run
// blocks every user task, issues delays while idle and wakes the tasks again,
// with wrapping and extreme delay values. Random ticks and delays follow.
// Both channels see random gaps and stalls. The monitor keeps its own
// scheduler state, updates it on every accepted input word and checks each
// result word against the oldest predicted snapshot.
// ----------------------------------------------------------------------------
module tb_round_robin_delay_scheduler_unit;
  import rrds_pkg::*;

  localparam int NT         = NumTasksDefault;
  localparam int IDLE_LIMIT = 3000;
  localparam int NUM_RANDOM = 500;

  typedef struct {
    logic             cmd;
    logic [TickW-1:0] dly;
    bit               drain;
  } sched_req_t;

  typedef struct {
    logic [TaskOutW-1:0] slot;
    logic [TickW-1:0]    ticks;
    logic [MaskOutW-1:0] mask;
  } sched_snap_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                command = CMD_TICK;
  logic [TickW-1:0]    delay_ticks = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [TaskOutW-1:0] current_task;
  logic [TickW-1:0]    tick_value;
  logic [MaskOutW-1:0] ready_mask;

  sched_req_t  pending_q[$];
  sched_snap_t snap_q[$];

  // scheduler state mirror
  logic [TickW-1:0] tick_ctr = '0;
  int               run_task = 1 % NT;
  logic [NT-1:0]    task_rdy = '1;
  logic [TickW-1:0] wake_at[NT];

  bit          in_taken = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  int          words_in = 0;
  int          total_words = 0;
  int          idle_cycles = 0;
  int          mismatches = 0;
  sched_snap_t want;

  round_robin_delay_scheduler_unit #(
    .NUM_TASKS(NT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .delay_ticks (delay_ticks),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .current_task(current_task),
    .tick_value  (tick_value),
    .ready_mask  (ready_mask)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int next_runnable(int from);
    int slot;
    slot = from;
    for (int n = 0; n < NT; n++) begin
      slot = (slot + 1) % NT;
      if (slot != 0 && task_rdy[slot]) return slot;
    end
    return 0;
  endfunction

  task automatic apply_command(input logic cmd, input logic [TickW-1:0] dly);
    sched_snap_t s;
    if (cmd == CMD_TICK) begin
      tick_ctr = tick_ctr + 1;
      for (int i = 1; i < NT; i++) begin
        if (!task_rdy[i] && tick_ctr >= wake_at[i]) task_rdy[i] = 1'b1;
      end
      run_task = next_runnable(run_task);
    end else if (run_task != 0) begin
      wake_at[run_task] = tick_ctr + dly;
      task_rdy[run_task] = 1'b0;
      run_task = next_runnable(run_task);
    end
    s.slot  = TaskOutW'(run_task);
    s.ticks = tick_ctr;
    s.mask  = MaskOutW'(task_rdy);
    snap_q.push_back(s);
  endtask

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TickW-1:0] rand_delay();
    int r;
    r = $urandom_range(0, 199);
    if (r == 0) return $urandom;
    if (r < 20) return 32'hFFFF_FFFF - $urandom_range(0, 15);
    if (r < 60) return $urandom_range(16, 40);
    return $urandom_range(0, 15);
  endfunction

  task automatic add_req(input logic cmd, input logic [TickW-1:0] dly, input bit drain);
    sched_req_t q;
    q.cmd   = cmd;
    q.dly   = dly;
    q.drain = drain;
    pending_q.push_back(q);
    total_words++;
  endtask

  // input side
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the stalled word
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (pending_q.size() == 0) begin
      in_valid <= 1'b0;
    end else if (pending_q[0].drain && snap_q.size() != 0) begin
      in_valid <= 1'b0;
    end else begin
      command     <= pending_q[0].cmd;
      delay_ticks <= pending_q[0].dly;
      in_valid    <= 1'b1;
      void'(pending_q.pop_front());
      send_gap = pick_gap(in_calm);
      if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
    end
  end

  // output side backpressure
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap(out_calm);
      if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (snap_q.size() == 0) begin
          $error("unexpected word: current_task %0d tick_value %0d ready_mask %b",
                 current_task, tick_value, ready_mask);
          mismatches++;
        end else begin
          want = snap_q.pop_front();
          if (current_task !== want.slot) begin
            $error("current_task: expected %0d, got %0d", want.slot, current_task);
            mismatches++;
          end
          if (tick_value !== want.ticks) begin
            $error("tick_value: expected %0d, got %0d", want.ticks, tick_value);
            mismatches++;
          end
          if (ready_mask !== want.mask) begin
            $error("ready_mask: expected %b, got %b", want.mask, ready_mask);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        words_in++;
        apply_command(command, delay_ticks);
      end
      if (in_taken || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic cmd;
    // directed: wrap-around and extreme delays, block every user task
    add_req(CMD_TICK, 32'hFFFF_FFFF, 1'b0);
    add_req(CMD_DELAY, 32'h0000_0000, 1'b0);
    add_req(CMD_DELAY, 32'hFFFF_FFFF, 1'b0);
    add_req(CMD_DELAY, 32'd1, 1'b0);
    add_req(CMD_DELAY, 32'd2, 1'b0);
    add_req(CMD_DELAY, 32'd3, 1'b0);
    add_req(CMD_DELAY, 32'd4, 1'b0);
    add_req(CMD_DELAY, 32'hFFFF_FFFE, 1'b0);
    // delay while idle is a no-op
    add_req(CMD_DELAY, 32'hFFFF_FFFF, 1'b0);
    add_req(CMD_DELAY, 32'h0000_0000, 1'b0);
    add_req(CMD_TICK, 32'h0000_0000, 1'b0);
    add_req(CMD_TICK, 32'h5555_AAAA, 1'b0);
    add_req(CMD_TICK, 32'hAAAA_5555, 1'b0);
    add_req(CMD_TICK, 32'h0000_0000, 1'b0);
    add_req(CMD_TICK, 32'h0000_0000, 1'b0);
    add_req(CMD_TICK, 32'h0000_0000, 1'b0);
    add_req(CMD_DELAY, 32'd1, 1'b1);
    add_req(CMD_TICK, 32'h0000_0000, 1'b0);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      cmd = $urandom_range(0, 1) ? CMD_DELAY : CMD_TICK;
      add_req(cmd, (cmd == CMD_DELAY) ? rand_delay() : $urandom, (i % 120) == 119);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    do @(negedge clk); while (words_in < total_words || snap_q.size() != 0);
    repeat (NT + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rrds_pkg.sv
rtl/rrds_cell.sv
rtl/round_robin_delay_scheduler_unit.sv
rtl/rrds_checker.sv
tb/tb_round_robin_delay_scheduler_unit.sv
